// ===== design/lsc_pkg.sv =====
// Shared constants and types for the line segment clipper.
`default_nettype none
package lsc_pkg;

  localparam logic [3:0] CODE_WEST  = 4'h1;
  localparam logic [3:0] CODE_EAST  = 4'h2;
  localparam logic [3:0] CODE_SOUTH = 4'h4;
  localparam logic [3:0] CODE_NORTH = 4'h8;
  localparam logic [3:0] CODE_EW    = CODE_WEST | CODE_EAST;
  localparam logic [3:0] CODE_NS    = CODE_NORTH | CODE_SOUTH;
  localparam logic [3:0] CODE_NONE  = 4'h0;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_RIGHT  = 2'd1;
  localparam logic [1:0] REG_TOP    = 2'd2;
  localparam logic [1:0] REG_BOTTOM = 2'd3;

  localparam int RST_LEFT   = 0;
  localparam int RST_RIGHT  = 639;
  localparam int RST_TOP    = 0;
  localparam int RST_BOTTOM = 479;

  localparam int LANES   = 4;
  localparam int LANE_SH = 0;
  localparam int LANE_SV = 1;
  localparam int LANE_EH = 2;
  localparam int LANE_EV = 3;

  localparam int CRD_SX = 0;
  localparam int CRD_SY = 1;
  localparam int CRD_EX = 2;
  localparam int CRD_EY = 3;

  typedef struct packed {
    logic [3:0] code_a;
    logic [3:0] code_b;
    logic       dx_zero;
    logic       dy_zero;
  } lsc_ctrl_t;

endpackage
`default_nettype wire

// ===== design/lsc_if.sv =====
// Valid/ready channel interfaces for segments in and clipped segments out.
`default_nettype none
interface lsc_in_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_out_if #(parameter int COORD_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic                  visible;
  logic [COORD_BITS-1:0] clipped_start_x;
  logic [COORD_BITS-1:0] clipped_start_y;
  logic [COORD_BITS-1:0] clipped_end_x;
  logic [COORD_BITS-1:0] clipped_end_y;
  modport source (output valid, visible, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, input ready);
  modport sink (input valid, visible, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, output ready);
endinterface
`default_nettype wire

// ===== design/line_segment_clipper.sv =====
// Top level of the line segment clipper: config registers, pipeline and divider lanes.
//
//   Port     Direction  Contents
//   in_ch    sink       start_x, start_y, end_x, end_y
//   out_ch   source     visible, clipped_start_x/y, clipped_end_x/y
//   cfg_*    write      cfg_we, cfg_index, cfg_wdata
//
// One segment enters per cycle while the output is not stalled; the four divider lanes
// resolve one quotient bit per stage.
// Reset is synchronous, clears the valid bits and loads the default clip rectangle.
// The input is not ready while reset is asserted.
// A result held at the output freezes the whole pipeline until the transaction completes.
`default_nettype none
module line_segment_clipper #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lsc_in_if.sink                     in_ch,
  lsc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_wdata
);

  localparam int N = COORD_BITS;
  localparam int D = N + 1;
  localparam int P = 2 * D;

  logic signed [N-1:0] clip_left_r, clip_right_r, clip_top_r, clip_bottom_r;
  logic                en;

  logic                                     s2_valid;
  lsc_pkg::lsc_ctrl_t                       s2_ctrl;
  logic [lsc_pkg::LANES-1:0][N-1:0]         s2_crd, in_crd;
  logic [lsc_pkg::LANES-1:0][P-1:0]         s2_prod, quo;
  logic [lsc_pkg::LANES-1:0][D-1:0]         s2_den;
  logic [lsc_pkg::LANES-1:0]                s2_neg;

  logic [P-1:0]                      vd_r;
  lsc_pkg::lsc_ctrl_t                ctrl_r [P];
  logic [lsc_pkg::LANES-1:0][N-1:0]  crd_r [P];
  logic [lsc_pkg::LANES-1:0]         neg_r [P];

  logic                              out_valid, out_visible;
  logic [lsc_pkg::LANES-1:0][N-1:0]  out_crd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= N'(lsc_pkg::RST_LEFT);
      clip_right_r  <= N'(lsc_pkg::RST_RIGHT);
      clip_top_r    <= N'(lsc_pkg::RST_TOP);
      clip_bottom_r <= N'(lsc_pkg::RST_BOTTOM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsc_pkg::REG_LEFT:   clip_left_r   <= $signed(cfg_wdata);
        lsc_pkg::REG_RIGHT:  clip_right_r  <= $signed(cfg_wdata);
        lsc_pkg::REG_TOP:    clip_top_r    <= $signed(cfg_wdata);
        lsc_pkg::REG_BOTTOM: clip_bottom_r <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign en          = !(out_valid && !out_ch.ready);
  assign in_ch.ready = en && rst_n;

  always_comb begin
    in_crd[lsc_pkg::CRD_SX] = in_ch.start_x;
    in_crd[lsc_pkg::CRD_SY] = in_ch.start_y;
    in_crd[lsc_pkg::CRD_EX] = in_ch.end_x;
    in_crd[lsc_pkg::CRD_EY] = in_ch.end_y;
  end

  lsc_prep #(.COORD_BITS(N)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_ch.valid),
    .in_crd      (in_crd),
    .clip_left   (clip_left_r),
    .clip_right  (clip_right_r),
    .clip_top    (clip_top_r),
    .clip_bottom (clip_bottom_r),
    .s2_valid_r  (s2_valid),
    .s2_ctrl_r   (s2_ctrl),
    .s2_crd_r    (s2_crd),
    .s2_prod_r   (s2_prod),
    .s2_den_r    (s2_den),
    .s2_neg_r    (s2_neg)
  );

  for (genvar l = 0; l < lsc_pkg::LANES; l++) begin : g_lane
    lsc_divpipe #(.NUM_W(P), .DEN_W(D)) u_div (
      .clk (clk),
      .en  (en),
      .num (s2_prod[l]),
      .den (s2_den[l]),
      .quo (quo[l])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else if (en) begin
      vd_r <= {vd_r[P-2:0], s2_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r[0] <= s2_ctrl;
      crd_r[0]  <= s2_crd;
      neg_r[0]  <= s2_neg;
      for (int s = 1; s < P; s++) begin
        ctrl_r[s] <= ctrl_r[s-1];
        crd_r[s]  <= crd_r[s-1];
        neg_r[s]  <= neg_r[s-1];
      end
    end
  end

  lsc_select #(.COORD_BITS(N)) u_select (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_valid      (vd_r[P-1]),
    .ctrl          (ctrl_r[P-1]),
    .crd           (crd_r[P-1]),
    .quo           (quo),
    .neg           (neg_r[P-1]),
    .clip_left     (clip_left_r),
    .clip_right    (clip_right_r),
    .clip_top      (clip_top_r),
    .clip_bottom   (clip_bottom_r),
    .out_valid_r   (out_valid),
    .out_visible_r (out_visible),
    .out_crd_r     (out_crd)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.visible         = out_visible;
  assign out_ch.clipped_start_x = out_crd[lsc_pkg::CRD_SX];
  assign out_ch.clipped_start_y = out_crd[lsc_pkg::CRD_SY];
  assign out_ch.clipped_end_x   = out_crd[lsc_pkg::CRD_EX];
  assign out_ch.clipped_end_y   = out_crd[lsc_pkg::CRD_EY];

  // A stalled output must freeze the stage valid bits that run beside the divider lanes.
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vd_r))
    else $error("divider stage valid bits moved during a stall");

  // Every segment leaving the front stages enters the divider lanes.
  a_prep_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    en && s2_valid |=> vd_r[0])
    else $error("segment lost between front stages and divider lanes");

  // A transaction at the input never completes while the output is stalled.
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ch.ready |-> !(in_ch.valid && in_ch.ready))
    else $error("input accepted while the pipeline is stalled");

endmodule
`default_nettype wire

// ===== design/lsc_prep.sv =====
// Front stages: region codes, edge distances, then magnitude products.
`default_nettype none
module lsc_prep #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        en,
  input  wire logic                                        in_valid,
  input  wire logic [lsc_pkg::LANES-1:0][COORD_BITS-1:0]   in_crd,
  input  wire logic signed [COORD_BITS-1:0]                clip_left,
  input  wire logic signed [COORD_BITS-1:0]                clip_right,
  input  wire logic signed [COORD_BITS-1:0]                clip_top,
  input  wire logic signed [COORD_BITS-1:0]                clip_bottom,
  output logic                                             s2_valid_r,
  output lsc_pkg::lsc_ctrl_t                               s2_ctrl_r,
  output logic [lsc_pkg::LANES-1:0][COORD_BITS-1:0]        s2_crd_r,
  output logic [lsc_pkg::LANES-1:0][2*COORD_BITS+1:0]      s2_prod_r,
  output logic [lsc_pkg::LANES-1:0][COORD_BITS:0]          s2_den_r,
  output logic [lsc_pkg::LANES-1:0]                        s2_neg_r
);

  localparam int N = COORD_BITS;
  localparam int D = N + 1;
  localparam int P = 2 * D;

  function automatic logic [3:0] region(input logic signed [N-1:0] x,
                                        input logic signed [N-1:0] y,
                                        input logic signed [N-1:0] l,
                                        input logic signed [N-1:0] r,
                                        input logic signed [N-1:0] t,
                                        input logic signed [N-1:0] b);
    logic [3:0] c;
    c = lsc_pkg::CODE_NONE;
    if (x < l) c = c | lsc_pkg::CODE_WEST;
    else if (x > r) c = c | lsc_pkg::CODE_EAST;
    if (y < t) c = c | lsc_pkg::CODE_NORTH;
    else if (y > b) c = c | lsc_pkg::CODE_SOUTH;
    return c;
  endfunction

  function automatic logic signed [D-1:0] ext(input logic signed [N-1:0] v);
    return D'(v);
  endfunction

  function automatic logic [D-1:0] mag(input logic signed [D-1:0] v);
    return v[D-1] ? D'(-v) : D'(v);
  endfunction

  logic signed [N-1:0] sx, sy, ex, ey;
  logic [3:0]          c1, c2;
  logic signed [N-1:0] he1, ve1, he2, ve2;

  logic                                      v1_r;
  lsc_pkg::lsc_ctrl_t                        ctrl1_r, ctrl1_nxt;
  logic [lsc_pkg::LANES-1:0][N-1:0]          crd1_r;
  logic signed [D-1:0]                       dx1_r, dy1_r, dx_nxt, dy_nxt;
  logic [lsc_pkg::LANES-1:0][D-1:0]          num1_r, num_nxt;

  logic [D-1:0] mdx, mdy;
  logic         sgn_d;
  logic [lsc_pkg::LANES-1:0][P-1:0] prod_nxt;
  logic [lsc_pkg::LANES-1:0][D-1:0] den_nxt;
  logic [lsc_pkg::LANES-1:0]        neg_nxt;

  always_comb begin
    sx  = $signed(in_crd[lsc_pkg::CRD_SX]);
    sy  = $signed(in_crd[lsc_pkg::CRD_SY]);
    ex  = $signed(in_crd[lsc_pkg::CRD_EX]);
    ey  = $signed(in_crd[lsc_pkg::CRD_EY]);
    c1  = region(sx, sy, clip_left, clip_right, clip_top, clip_bottom);
    c2  = region(ex, ey, clip_left, clip_right, clip_top, clip_bottom);
    he1 = ((c1 & lsc_pkg::CODE_NORTH) != lsc_pkg::CODE_NONE) ? clip_top : clip_bottom;
    he2 = ((c2 & lsc_pkg::CODE_NORTH) != lsc_pkg::CODE_NONE) ? clip_top : clip_bottom;
    ve1 = ((c1 & lsc_pkg::CODE_EAST) != lsc_pkg::CODE_NONE) ? clip_right : clip_left;
    ve2 = ((c2 & lsc_pkg::CODE_EAST) != lsc_pkg::CODE_NONE) ? clip_right : clip_left;
    dx_nxt = ext(ex) - ext(sx);
    dy_nxt = ext(ey) - ext(sy);
    num_nxt[lsc_pkg::LANE_SH] = ext(he1) - ext(sy);
    num_nxt[lsc_pkg::LANE_SV] = ext(ve1) - ext(sx);
    num_nxt[lsc_pkg::LANE_EH] = ext(he2) - ext(ey);
    num_nxt[lsc_pkg::LANE_EV] = ext(ve2) - ext(ex);
    ctrl1_nxt.code_a  = c1;
    ctrl1_nxt.code_b  = c2;
    ctrl1_nxt.dx_zero = (dx_nxt == '0);
    ctrl1_nxt.dy_zero = (dy_nxt == '0);
  end

  always_comb begin
    mdx   = mag(dx1_r);
    mdy   = mag(dy1_r);
    sgn_d = dx1_r[D-1] ^ dy1_r[D-1];
    for (int i = 0; i < lsc_pkg::LANES; i++) begin
      neg_nxt[i] = num1_r[i][D-1] ^ sgn_d;
    end
    prod_nxt[lsc_pkg::LANE_SH] = P'(mag(num1_r[lsc_pkg::LANE_SH])) * P'(mdx);
    prod_nxt[lsc_pkg::LANE_EH] = P'(mag(num1_r[lsc_pkg::LANE_EH])) * P'(mdx);
    prod_nxt[lsc_pkg::LANE_SV] = P'(mag(num1_r[lsc_pkg::LANE_SV])) * P'(mdy);
    prod_nxt[lsc_pkg::LANE_EV] = P'(mag(num1_r[lsc_pkg::LANE_EV])) * P'(mdy);
    den_nxt[lsc_pkg::LANE_SH]  = mdy;
    den_nxt[lsc_pkg::LANE_EH]  = mdy;
    den_nxt[lsc_pkg::LANE_SV]  = mdx;
    den_nxt[lsc_pkg::LANE_EV]  = mdx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      s2_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl1_r   <= ctrl1_nxt;
      crd1_r    <= in_crd;
      dx1_r     <= dx_nxt;
      dy1_r     <= dy_nxt;
      num1_r    <= num_nxt;
      s2_ctrl_r <= ctrl1_r;
      s2_crd_r  <= crd1_r;
      s2_prod_r <= prod_nxt;
      s2_den_r  <= den_nxt;
      s2_neg_r  <= neg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/lsc_divpipe.sv =====
// Pipelined restoring divider that resolves one quotient bit per stage.
`default_nettype none
module lsc_divpipe #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 17
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0]      quo
);

  localparam int ACC_W = DEN_W + NUM_W;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [ACC_W-1:0] acc_r;
    logic [DEN_W-1:0] den_r;
    logic [ACC_W-1:0] acc_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic [ACC_W-1:0] acc_nxt;

    if (s == 0) begin : g_first
      assign acc_in = {{DEN_W{1'b0}}, num};
      assign den_in = den;
    end else begin : g_next
      assign acc_in = g_stage[s-1].acc_r;
      assign den_in = g_stage[s-1].den_r;
    end

    always_comb begin
      trial = acc_in[ACC_W-1:NUM_W-1];
      diff  = trial - {1'b0, den_in};
      if (trial >= {1'b0, den_in}) begin
        acc_nxt = {diff[DEN_W-1:0], acc_in[NUM_W-2:0], 1'b1};
      end else begin
        acc_nxt = {trial[DEN_W-1:0], acc_in[NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r <= acc_nxt;
        den_r <= den_in;
      end
    end
  end

  assign quo = g_stage[NUM_W-1].acc_r[NUM_W-1:0];

endmodule
`default_nettype wire

// ===== design/lsc_select.sv =====
// Back stages: edge point selection per endpoint, then the final bounds check.
`default_nettype none
module lsc_select #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        en,
  input  wire logic                                        in_valid,
  input  wire lsc_pkg::lsc_ctrl_t                          ctrl,
  input  wire logic [lsc_pkg::LANES-1:0][COORD_BITS-1:0]   crd,
  input  wire logic [lsc_pkg::LANES-1:0][2*COORD_BITS+1:0] quo,
  input  wire logic [lsc_pkg::LANES-1:0]                   neg,
  input  wire logic signed [COORD_BITS-1:0]                clip_left,
  input  wire logic signed [COORD_BITS-1:0]                clip_right,
  input  wire logic signed [COORD_BITS-1:0]                clip_top,
  input  wire logic signed [COORD_BITS-1:0]                clip_bottom,
  output logic                                             out_valid_r,
  output logic                                             out_visible_r,
  output logic [lsc_pkg::LANES-1:0][COORD_BITS-1:0]        out_crd_r
);

  localparam int N = COORD_BITS;
  localparam int P = 2 * N + 2;
  localparam int W = P + 2;

  function automatic logic signed [W-1:0] wx(input logic signed [N-1:0] v);
    return W'(v);
  endfunction

  function automatic logic signed [W-1:0] sq(input logic [P-1:0] q, input logic n);
    logic signed [W-1:0] m;
    m = $signed(W'(q));
    return n ? -m : m;
  endfunction

  logic                         v3_r;
  logic                         acc3_r, acc3_nxt, rej3_r, rej3_nxt;
  logic [1:0]                   ok3_r, ok3_nxt;
  logic [lsc_pkg::LANES-1:0][W-1:0] pt3_r, pt3_nxt;
  logic [lsc_pkg::LANES-1:0][N-1:0] crd3_r;
  logic                         vis_nxt;
  logic [1:0]                   in_box;

  always_comb begin
    logic [3:0]          code;
    logic signed [W-1:0] ax, ay, hx, vy, he, ve;
    int                  b;
    int                  lh;
    int                  lv;
    for (int e = 0; e < 2; e++) begin
      b    = 2 * e;
      lh   = (e == 0) ? lsc_pkg::LANE_SH : lsc_pkg::LANE_EH;
      lv   = (e == 0) ? lsc_pkg::LANE_SV : lsc_pkg::LANE_EV;
      code = (e == 0) ? ctrl.code_a : ctrl.code_b;
      ax   = wx($signed(crd[b]));
      ay   = wx($signed(crd[b+1]));
      hx   = ax + sq(quo[lh], neg[lh]);
      vy   = ay + sq(quo[lv], neg[lv]);
      he   = ((code & lsc_pkg::CODE_NORTH) != lsc_pkg::CODE_NONE) ? wx(clip_top)
                                                                  : wx(clip_bottom);
      ve   = ((code & lsc_pkg::CODE_EAST) != lsc_pkg::CODE_NONE) ? wx(clip_right)
                                                                 : wx(clip_left);
      priority if (code == lsc_pkg::CODE_NONE) begin
        ok3_nxt[e]   = 1'b1;
        pt3_nxt[b]   = ax;
        pt3_nxt[b+1] = ay;
      end else if ((code & lsc_pkg::CODE_NS) != lsc_pkg::CODE_NONE && ctrl.dy_zero) begin
        ok3_nxt[e]   = 1'b0;
        pt3_nxt[b]   = ax;
        pt3_nxt[b+1] = ay;
      end else if ((code & lsc_pkg::CODE_NS) != lsc_pkg::CODE_NONE &&
                   ((code & lsc_pkg::CODE_EW) == lsc_pkg::CODE_NONE ||
                    (hx >= wx(clip_left) && hx <= wx(clip_right)))) begin
        ok3_nxt[e]   = 1'b1;
        pt3_nxt[b]   = hx;
        pt3_nxt[b+1] = he;
      end else begin
        ok3_nxt[e]   = !ctrl.dx_zero;
        pt3_nxt[b]   = ve;
        pt3_nxt[b+1] = vy;
      end
    end
    acc3_nxt = (ctrl.code_a == lsc_pkg::CODE_NONE) && (ctrl.code_b == lsc_pkg::CODE_NONE);
    rej3_nxt = !acc3_nxt && (ctrl.code_a == ctrl.code_b);
  end

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      in_box[e] = $signed(pt3_r[2*e]) >= wx(clip_left) &&
                  $signed(pt3_r[2*e]) <= wx(clip_right) &&
                  $signed(pt3_r[2*e+1]) >= wx(clip_top) &&
                  $signed(pt3_r[2*e+1]) <= wx(clip_bottom);
    end
    vis_nxt = acc3_r || (!rej3_r && (&ok3_r) && (&in_box));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v3_r        <= in_valid;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc3_r        <= acc3_nxt;
      rej3_r        <= rej3_nxt;
      ok3_r         <= ok3_nxt;
      pt3_r         <= pt3_nxt;
      crd3_r        <= crd;
      out_visible_r <= vis_nxt;
      for (int i = 0; i < lsc_pkg::LANES; i++) begin
        out_crd_r[i] <= vis_nxt ? pt3_r[i][N-1:0] : crd3_r[i];
      end
    end
  end

endmodule
`default_nettype wire
